/* rtl/core/ppc_pkg.sv */
// Shared constants and types for the polygon plane clipper.
`timescale 1ns / 1ps

package ppc_pkg;

    localparam int NORMAL_BITS  = 18;  // plane normal, signed Q2.16
    localparam int DIST_BITS    = 50;  // signed distance, Q34.16
    localparam int FRAC_BITS    = 24;  // crossing fraction, Q0.24
    localparam int ACC_BITS     = 63;  // distance accumulator, holds three saturated products
    localparam int SAT_SHIFT    = 60;  // product magnitude limit is 2^60
    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NORMAL_X = 3'd0,
        CFG_NORMAL_Y = 3'd1,
        CFG_NORMAL_Z = 3'd2,
        CFG_PLANE_X  = 3'd3,
        CFG_PLANE_Y  = 3'd4,
        CFG_PLANE_Z  = 3'd5
    } cfg_reg_t;

endpackage

/* rtl/core/ppc_if.sv */
// Channel interfaces of the polygon plane clipper: vertex in, clipped vertex out, config write.
`timescale 1ns / 1ps

interface ppc_vertex_if #(parameter int COORD_BITS = 31) ();
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic signed [COORD_BITS-1:0] pz;
    logic                         last_vertex;

    modport source (output valid, kind, px, py, pz, last_vertex, input ready);
    modport sink (input valid, kind, px, py, pz, last_vertex, output ready);
endinterface

interface ppc_clip_if #(parameter int COORD_BITS = 31) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] ox;
    logic signed [COORD_BITS-1:0] oy;
    logic signed [COORD_BITS-1:0] oz;
    logic                         out_valid;
    logic                         out_last;

    modport source (output valid, ox, oy, oz, out_valid, out_last, input ready);
    modport sink (input valid, ox, oy, oz, out_valid, out_last, output ready);
endinterface

interface ppc_cfg_if #(parameter int DATA_BITS = 31) ();
    import ppc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [DATA_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/polygon_plane_clipper.sv */
// Polygon plane clipper: one clip stage against a configured plane, shared add/sub unit.
//
//   channel   dir   words per vertex   payload
//   vertex    in    1                  kind, px, py, pz, last_vertex
//   clipped   out   0 to 2             ox, oy, oz, out_valid, out_last
//   cfg       in    1 per write        index, data (always ready)
//
// Everything runs through one adder under the sequencer. A vertex first gets
// its distance (18-step shift-add multiply per axis), then, when its edge
// crosses the plane, a 26-step restoring divide and a 25-step multiply per
// axis. Results leave through one output register; vertex ready stays low
// until the last word of the vertex is taken. rst_n clears the sequencer and
// the stored previous vertex at once, and sets the config to the plane z = 0
// with normal +z.
`timescale 1ns / 1ps

module polygon_plane_clipper #(
    parameter int COORD_BITS = 31
) (
    input  logic          clk,
    input  logic          rst_n,
    ppc_vertex_if.sink    vertex,
    ppc_clip_if.source    clipped,
    ppc_cfg_if.sink       cfg
);
    import ppc_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int MW   = FRAC_BITS + 1;            // multiplier register
    localparam int NPAD = MW - NORMAL_BITS;
    localparam int PW   = CB + MW;                  // product register
    localparam int EW   = (PW > ACC_BITS) ? PW : ACC_BITS;
    localparam int AW   = (PW + 1 > 64) ? PW + 1 : 64;  // shared adder
    localparam int DENW = DIST_BITS + 1;
    localparam int RW   = DIST_BITS + 2;
    localparam int QW   = FRAC_BITS + 2;
    localparam int CNTW = $clog2(QW + 1);

    localparam logic [1:0] LAST_AXIS = 2'd2;

    localparam logic [AW-1:0]       CMAX = (AW'(1) << (CB - 1)) - AW'(1);
    localparam logic [AW-1:0]       CMIN = ~CMAX;
    localparam logic [ACC_BITS-1:0] DMAX = (ACC_BITS'(1) << (DIST_BITS - 1)) - ACC_BITS'(1);
    localparam logic [ACC_BITS-1:0] DMIN = ~DMAX;
    localparam logic [EW-1:0]       SAT_LIM = EW'(1) << SAT_SHIFT;

    typedef enum logic [15:0] {
        S_IDLE   = 16'b0000_0000_0000_0001,
        S_DIFF   = 16'b0000_0000_0000_0010,
        S_ABS    = 16'b0000_0000_0000_0100,
        S_MUL    = 16'b0000_0000_0000_1000,
        S_ACC    = 16'b0000_0000_0001_0000,
        S_DECIDE = 16'b0000_0000_0010_0000,
        S_NUM    = 16'b0000_0000_0100_0000,
        S_DIV    = 16'b0000_0000_1000_0000,
        S_FRAC   = 16'b0000_0001_0000_0000,
        S_LDIFF  = 16'b0000_0010_0000_0000,
        S_LABS   = 16'b0000_0100_0000_0000,
        S_LMUL   = 16'b0000_1000_0000_0000,
        S_LRND   = 16'b0001_0000_0000_0000,
        S_LADD   = 16'b0010_0000_0000_0000,
        S_LOAD   = 16'b0100_0000_0000_0000,
        S_OUT    = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // config and carried state
    logic signed [NORMAL_BITS-1:0] normal_reg [3];
    logic signed [CB-1:0]          plane_reg  [3];
    logic signed [CB-1:0]          prev_reg   [3];
    logic signed [DIST_BITS-1:0]   prevd_reg;
    logic                          pend_reg;

    // datapath
    logic signed [CB-1:0]        cur_reg   [3];
    logic signed [CB-1:0]        cross_reg [3];
    logic                        kind_reg;
    logic                        last_reg;
    logic [1:0]                  axis_reg;
    logic [CNTW-1:0]             cnt_reg;
    logic [AW-1:0]               tmp_reg;
    logic [CB-1:0]               mcand_reg;
    logic [MW-1:0]               mul_reg;
    logic [PW-1:0]               prod_reg;
    logic                        sign_reg;
    logic [ACC_BITS-1:0]         acc_reg;
    logic signed [DIST_BITS-1:0] d2_reg;
    logic                        in2_reg;
    logic                        xing_reg;
    logic [DENW-1:0]             den_reg;
    logic [RW-1:0]               rem_reg;
    logic [QW-1:0]               q_reg;
    logic [MW-1:0]               frac_reg;
    logic signed [CB-1:0]        ox_reg, oy_reg, oz_reg;
    logic                        ovalid_reg, olast_reg;

    // shared adder
    logic [AW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_sub;

    logic signed [CB-1:0]          cur_sel, plane_sel, prev_sel;
    logic signed [NORMAL_BITS-1:0] normal_sel;
    logic [NORMAL_BITS-1:0]        norm_mag;
    logic                          norm_neg;
    logic                          tmp_neg;
    logic [AW-1:0]                 cur_ext, plane_ext, prev_ext, d1_ext, d2_ext;
    logic [EW-1:0]                 prod_ext, satp_ext;
    logic [ACC_BITS-1:0]           satp;
    logic signed [DIST_BITS-1:0]   d2_now;
    logic                          in1, in2_now;
    logic [RW-1:0]                 rtrial;
    logic [CB-1:0]                 step;
    logic signed [CB-1:0]          lerp_res;

    assign cur_sel    = cur_reg[axis_reg];
    assign plane_sel  = plane_reg[axis_reg];
    assign prev_sel   = prev_reg[axis_reg];
    assign normal_sel = normal_reg[axis_reg];

    assign cur_ext   = {{(AW - CB){cur_sel[CB-1]}}, cur_sel};
    assign plane_ext = {{(AW - CB){plane_sel[CB-1]}}, plane_sel};
    assign prev_ext  = {{(AW - CB){prev_sel[CB-1]}}, prev_sel};
    assign d1_ext    = {{(AW - DIST_BITS){prevd_reg[DIST_BITS-1]}}, prevd_reg};
    assign d2_ext    = {{(AW - DIST_BITS){d2_now[DIST_BITS-1]}}, d2_now};

    assign norm_neg = normal_sel[NORMAL_BITS-1];
    assign norm_mag = norm_neg ? (~normal_sel + NORMAL_BITS'(1)) : normal_sel;
    assign tmp_neg  = tmp_reg[AW-1];

    // product magnitude saturates at 2^60
    assign prod_ext = EW'(prod_reg);
    assign satp_ext = (prod_ext > SAT_LIM) ? SAT_LIM : prod_ext;
    assign satp     = satp_ext[ACC_BITS-1:0];

    always_comb
    begin
        if ($signed(acc_reg) > $signed(DMAX))
            d2_now = DMAX[DIST_BITS-1:0];
        else if ($signed(acc_reg) < $signed(DMIN))
            d2_now = DMIN[DIST_BITS-1:0];
        else
            d2_now = acc_reg[DIST_BITS-1:0];
    end

    assign in1     = (prevd_reg <= 0);
    assign in2_now = (d2_now <= 0);

    assign rtrial = (cnt_reg == CNTW'(QW)) ? rem_reg : {rem_reg[RW-2:0], 1'b0};
    assign step   = tmp_reg[FRAC_BITS +: CB];

    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_DIFF:
            begin
                alu_a   = cur_ext;
                alu_b   = plane_ext;
                alu_sub = 1'b1;
            end
            S_ABS, S_LABS:
            begin
                alu_b   = tmp_reg;
                alu_sub = tmp_neg;
            end
            S_MUL, S_LMUL:
            begin
                alu_a = AW'({prod_reg[PW-2:0], 1'b0});
                alu_b = mul_reg[MW-1] ? AW'(mcand_reg) : '0;
            end
            S_ACC:
            begin
                alu_a   = {{(AW - ACC_BITS){acc_reg[ACC_BITS-1]}}, acc_reg};
                alu_b   = AW'(satp);
                alu_sub = sign_reg;
            end
            S_DECIDE:
            begin
                // den = |d1| + |d2| when the two sides differ
                alu_a   = in1 ? d2_ext : d1_ext;
                alu_b   = in1 ? d1_ext : d2_ext;
                alu_sub = 1'b1;
            end
            S_NUM:
            begin
                alu_b   = d1_ext;
                alu_sub = in1;
            end
            S_DIV:
            begin
                alu_a   = AW'(rtrial);
                alu_b   = AW'(den_reg);
                alu_sub = 1'b1;
            end
            S_FRAC:
            begin
                alu_a = AW'(q_reg);
                alu_b = AW'(1);
            end
            S_LDIFF:
            begin
                alu_a   = cur_ext;
                alu_b   = prev_ext;
                alu_sub = 1'b1;
            end
            S_LRND:
            begin
                alu_a = AW'(prod_reg);
                alu_b = AW'(1) << (FRAC_BITS - 1);
            end
            S_LADD:
            begin
                alu_a   = prev_ext;
                alu_b   = AW'(step);
                alu_sub = sign_reg;
            end
            default:
            begin
                alu_a = '0;
            end
        endcase
    end

    assign alu_sum = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

    always_comb
    begin
        if ($signed(alu_sum) > $signed(CMAX))
            lerp_res = CMAX[CB-1:0];
        else if ($signed(alu_sum) < $signed(CMIN))
            lerp_res = CMIN[CB-1:0];
        else
            lerp_res = alu_sum[CB-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (vertex.valid) state_next = S_DIFF;
            S_DIFF:   state_next = S_ABS;
            S_ABS:    state_next = S_MUL;
            S_MUL:    if (cnt_reg == CNTW'(1)) state_next = S_ACC;
            S_ACC:    state_next = (axis_reg == LAST_AXIS) ? S_DECIDE : S_DIFF;
            S_DECIDE: state_next = (kind_reg && (in1 != in2_now)) ? S_NUM : S_LOAD;
            S_NUM:    state_next = S_DIV;
            S_DIV:    if (cnt_reg == CNTW'(1)) state_next = S_FRAC;
            S_FRAC:   state_next = S_LDIFF;
            S_LDIFF:  state_next = S_LABS;
            S_LABS:   state_next = S_LMUL;
            S_LMUL:   if (cnt_reg == CNTW'(1)) state_next = S_LRND;
            S_LRND:   state_next = S_LADD;
            S_LADD:   state_next = (axis_reg == LAST_AXIS) ? S_LOAD : S_LDIFF;
            S_LOAD:
            begin
                if (kind_reg && (xing_reg || in2_reg || last_reg))
                    state_next = S_OUT;
                else
                    state_next = S_IDLE;
            end
            S_OUT:    if (clipped.ready && !pend_reg) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control, config and carried state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            normal_reg[0] <= '0;
            normal_reg[1] <= '0;
            normal_reg[2] <= NORMAL_BITS'(65536);
            plane_reg[0]  <= '0;
            plane_reg[1]  <= '0;
            plane_reg[2]  <= '0;
            prev_reg[0]   <= '0;
            prev_reg[1]   <= '0;
            prev_reg[2]   <= '0;
            prevd_reg     <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_NORMAL_X: normal_reg[0] <= cfg.data[NORMAL_BITS-1:0];
                    CFG_NORMAL_Y: normal_reg[1] <= cfg.data[NORMAL_BITS-1:0];
                    CFG_NORMAL_Z: normal_reg[2] <= cfg.data[NORMAL_BITS-1:0];
                    CFG_PLANE_X:  plane_reg[0]  <= cfg.data[CB-1:0];
                    CFG_PLANE_Y:  plane_reg[1]  <= cfg.data[CB-1:0];
                    CFG_PLANE_Z:  plane_reg[2]  <= cfg.data[CB-1:0];
                    default:      ;
                endcase
            end
            if (state_reg == S_LOAD)
            begin
                prev_reg[0] <= cur_reg[0];
                prev_reg[1] <= cur_reg[1];
                prev_reg[2] <= cur_reg[2];
                prevd_reg   <= d2_reg;
                pend_reg    <= kind_reg && xing_reg && in2_reg;
            end
            else if ((state_reg == S_OUT) && clipped.ready)
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (vertex.valid)
                begin
                    cur_reg[0] <= vertex.px;
                    cur_reg[1] <= vertex.py;
                    cur_reg[2] <= vertex.pz;
                    kind_reg   <= vertex.kind;
                    last_reg   <= vertex.last_vertex;
                    acc_reg    <= '0;
                    axis_reg   <= '0;
                end
            end
            S_DIFF, S_LDIFF, S_LRND:
            begin
                tmp_reg <= alu_sum;
            end
            S_ABS:
            begin
                mcand_reg <= alu_sum[CB-1:0];
                mul_reg   <= {norm_mag, {NPAD{1'b0}}};
                prod_reg  <= '0;
                cnt_reg   <= CNTW'(NORMAL_BITS);
                sign_reg  <= tmp_neg ^ norm_neg;
            end
            S_MUL, S_LMUL:
            begin
                prod_reg <= alu_sum[PW-1:0];
                mul_reg  <= {mul_reg[MW-2:0], 1'b0};
                cnt_reg  <= cnt_reg - CNTW'(1);
            end
            S_ACC:
            begin
                acc_reg  <= alu_sum[ACC_BITS-1:0];
                axis_reg <= (axis_reg == LAST_AXIS) ? 2'd0 : axis_reg + 2'd1;
            end
            S_DECIDE:
            begin
                d2_reg   <= d2_now;
                in2_reg  <= in2_now;
                xing_reg <= in1 != in2_now;
                den_reg  <= alu_sum[DENW-1:0];
            end
            S_NUM:
            begin
                rem_reg <= alu_sum[RW-1:0];
                q_reg   <= '0;
                cnt_reg <= CNTW'(QW);
            end
            S_DIV:
            begin
                // restoring step: keep the difference when it did not go negative
                if (!alu_sum[AW-1])
                begin
                    rem_reg <= alu_sum[RW-1:0];
                    q_reg   <= {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rtrial;
                    q_reg   <= {q_reg[QW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CNTW'(1);
            end
            S_FRAC:
            begin
                frac_reg <= alu_sum[QW-1:1];
            end
            S_LABS:
            begin
                mcand_reg <= alu_sum[CB-1:0];
                mul_reg   <= frac_reg;
                prod_reg  <= '0;
                cnt_reg   <= CNTW'(MW);
                sign_reg  <= tmp_neg;
            end
            S_LADD:
            begin
                cross_reg[axis_reg] <= lerp_res;
                axis_reg <= (axis_reg == LAST_AXIS) ? 2'd0 : axis_reg + 2'd1;
            end
            S_LOAD:
            begin
                if (xing_reg)
                begin
                    ox_reg     <= cross_reg[0];
                    oy_reg     <= cross_reg[1];
                    oz_reg     <= cross_reg[2];
                    ovalid_reg <= 1'b1;
                    olast_reg  <= last_reg && !in2_reg;
                end
                else if (in2_reg)
                begin
                    ox_reg     <= cur_reg[0];
                    oy_reg     <= cur_reg[1];
                    oz_reg     <= cur_reg[2];
                    ovalid_reg <= 1'b1;
                    olast_reg  <= last_reg;
                end
                else
                begin
                    // bare end marker, only sent on the last vertex
                    ox_reg     <= '0;
                    oy_reg     <= '0;
                    oz_reg     <= '0;
                    ovalid_reg <= 1'b0;
                    olast_reg  <= 1'b1;
                end
            end
            S_OUT:
            begin
                // second word: the inside vertex after its crossing point
                if (clipped.ready && pend_reg)
                begin
                    ox_reg     <= cur_reg[0];
                    oy_reg     <= cur_reg[1];
                    oz_reg     <= cur_reg[2];
                    ovalid_reg <= 1'b1;
                    olast_reg  <= last_reg;
                end
            end
            default:
            begin
                tmp_reg <= tmp_reg;
            end
        endcase
    end

    assign vertex.ready      = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign clipped.valid     = (state_reg == S_OUT);
    assign clipped.ox        = ox_reg;
    assign clipped.oy        = oy_reg;
    assign clipped.oz        = oz_reg;
    assign clipped.out_valid = ovalid_reg;
    assign clipped.out_last  = olast_reg;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for polygon_plane_clipper: scoreboard class with clipping predictor.
`timescale 1ns / 1ps

import ppc_pkg::*;

typedef enum logic {KIND_PRIME = 1'b0, KIND_VERTEX = 1'b1} vertex_kind_t;

class clip_scoreboard #(int CB = 31);
    typedef struct {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
        logic                 vld;
        logic                 lst;
    } clip_word_t;

    logic signed [NORMAL_BITS-1:0] normal [3];
    logic signed [CB-1:0]          anchor [3];
    logic signed [CB-1:0]          prev_v [3];
    logic signed [DIST_BITS-1:0]   prev_d;
    clip_word_t                    pending [$];
    int                            errors;

    function new();
        normal[0] = '0;
        normal[1] = '0;
        normal[2] = 65536;
        anchor[0] = '0;
        anchor[1] = '0;
        anchor[2] = '0;
        prev_v[0] = '0;
        prev_v[1] = '0;
        prev_v[2] = '0;
        prev_d = '0;
        errors = 0;
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 100)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    function void write_reg(cfg_reg_t idx, logic [CB-1:0] data);
        case (idx)
            CFG_NORMAL_X: normal[0] = data[NORMAL_BITS-1:0];
            CFG_NORMAL_Y: normal[1] = data[NORMAL_BITS-1:0];
            CFG_NORMAL_Z: normal[2] = data[NORMAL_BITS-1:0];
            CFG_PLANE_X:  anchor[0] = data;
            CFG_PLANE_Y:  anchor[1] = data;
            CFG_PLANE_Z:  anchor[2] = data;
            default: ;
        endcase
    endfunction

    function longint clamp_to(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function longint sat_product(longint a, longint b);
        longint p;
        longint lim;
        lim = longint'(1) <<< SAT_SHIFT;
        p = a * b;
        if (p > lim)
            p = lim;
        if (p < -lim)
            p = -lim;
        return p;
    endfunction

    function longint plane_distance(longint cx, longint cy, longint cz);
        longint s;
        s = sat_product(normal[0], cx - anchor[0])
          + sat_product(normal[1], cy - anchor[1])
          + sat_product(normal[2], cz - anchor[2]);
        return clamp_to(s, DIST_BITS);
    endfunction

    // |d1| / (|d1| + |d2|) in Q0.24, one guard bit then round half up
    function longint unsigned crossing_frac(longint d1, longint d2);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        longint unsigned r;
        int i;
        num = magnitude(d1);
        den = num + magnitude(d2);
        q = 0;
        r = num;
        if (den == 0)
            return 0;
        if (r >= den)
        begin
            q = 1;
            r = r - den;
        end
        for (i = 0; i < FRAC_BITS + 1; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 1;
            end
        end
        return (q + 1) >> 1;
    endfunction

    function longint lerp_axis(longint a, longint b, longint unsigned f);
        longint d;
        longint unsigned m;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned stp;
        longint r;
        d = b - a;
        m = magnitude(d);
        hi = m >> FRAC_BITS;
        lo = m & ((longint'(1) << FRAC_BITS) - 1);
        stp = hi * f + ((lo * f + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
        r = (d < 0) ? a - longint'(stp) : a + longint'(stp);
        return clamp_to(r, CB);
    endfunction

    function void note_vertex(vertex_kind_t kind, logic signed [CB-1:0] x,
                              logic signed [CB-1:0] y, logic signed [CB-1:0] z,
                              logic lastv);
        clip_word_t w [2];
        int n;
        longint d1;
        longint d2;
        longint unsigned f;
        bit in1;
        bit in2;
        d1 = prev_d;
        d2 = plane_distance(x, y, z);
        n = 0;
        if (kind == KIND_VERTEX)
        begin
            in1 = (d1 <= 0);
            in2 = (d2 <= 0);
            if (in1 != in2)
            begin
                f = crossing_frac(d1, d2);
                w[n].x = lerp_axis(prev_v[0], x, f);
                w[n].y = lerp_axis(prev_v[1], y, f);
                w[n].z = lerp_axis(prev_v[2], z, f);
                w[n].vld = 1'b1;
                w[n].lst = 1'b0;
                n++;
            end
            if (in2)
            begin
                w[n].x = x;
                w[n].y = y;
                w[n].z = z;
                w[n].vld = 1'b1;
                w[n].lst = 1'b0;
                n++;
            end
            if (lastv)
            begin
                // nothing emitted: bare end marker
                if (n == 0)
                begin
                    w[0].x = '0;
                    w[0].y = '0;
                    w[0].z = '0;
                    w[0].vld = 1'b0;
                    n = 1;
                end
                w[n-1].lst = 1'b1;
            end
            for (int i = 0; i < n; i++)
                pending.push_back(w[i]);
        end
        prev_v[0] = x;
        prev_v[1] = y;
        prev_v[2] = z;
        prev_d = d2;
    endfunction

    task check_word(logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                    logic signed [CB-1:0] z, logic vld, logic lst);
        clip_word_t e;
        if (pending.size() == 0)
        begin
            report($sformatf("clipped word (%0d,%0d,%0d) with none expected", x, y, z));
            return;
        end
        e = pending.pop_front();
        if (x !== e.x)
            report($sformatf("ox got %0d want %0d", x, e.x));
        if (y !== e.y)
            report($sformatf("oy got %0d want %0d", y, e.y));
        if (z !== e.z)
            report($sformatf("oz got %0d want %0d", z, e.z));
        if (vld !== e.vld)
            report($sformatf("out_valid got %b want %b", vld, e.vld));
        if (lst !== e.lst)
            report($sformatf("out_last got %b want %b", lst, e.lst));
    endtask
endclass

module testbench;
    localparam int     COORD_BITS    = 31;
    localparam int     SETTLE_CYCLES = 250;
    localparam int     IDLE_LIMIT    = 5000;
    localparam int     ITEM_TARGET   = 1320;
    localparam longint CMAX          = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint CMIN          = -(longint'(1) <<< (COORD_BITS - 1));
    localparam longint UNIT          = 65536;

    logic clk = 1'b0;
    logic rst_n;

    ppc_vertex_if #(.COORD_BITS(COORD_BITS)) vtx ();
    ppc_clip_if   #(.COORD_BITS(COORD_BITS)) clp ();
    ppc_cfg_if    #(.DATA_BITS(COORD_BITS))  cfg_ch ();

    polygon_plane_clipper #(.COORD_BITS(COORD_BITS)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .vertex  (vtx),
        .clipped (clp),
        .cfg     (cfg_ch)
    );

    clip_scoreboard #(COORD_BITS) sb;
    bit     calm;
    int     items_sent;
    int     idle_cycles = 0;
    longint plane_pt [3];

    always #2 clk = ~clk;

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // spread 0 means anywhere in the coordinate range
    function automatic logic signed [COORD_BITS-1:0] near_coord(longint c, int spread);
        longint v;
        logic [31:0] r;
        if (spread <= 0)
        begin
            r = $urandom();
            return r[COORD_BITS-1:0];
        end
        v = c + longint'($urandom_range(0, 2 * spread)) - spread;
        if (v > CMAX)
            v = CMAX;
        if (v < CMIN)
            v = CMIN;
        return v[COORD_BITS-1:0];
    endfunction

    task automatic send_vertex(vertex_kind_t k, logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y,
                               logic signed [COORD_BITS-1:0] z, logic lastv);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            vtx.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        vtx.valid <= 1'b1;
        vtx.kind <= k;
        vtx.px <= x;
        vtx.py <= y;
        vtx.pz <= z;
        vtx.last_vertex <= lastv;
        @(posedge clk);
        while (!vtx.ready)
            @(posedge clk);
        sb.note_vertex(k, x, y, z, lastv);
        items_sent++;
        @(negedge clk);
    endtask

    // hold off until every expected word is out and the block has gone quiet
    task automatic settle();
        vtx.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_plane(longint nx, longint ny, longint nz,
                                 longint ax, longint ay, longint az);
        cfg_reg_t             regs [6];
        logic [COORD_BITS-1:0] vals [6];
        int i;
        regs = '{CFG_NORMAL_X, CFG_NORMAL_Y, CFG_NORMAL_Z,
                 CFG_PLANE_X, CFG_PLANE_Y, CFG_PLANE_Z};
        vals[0] = nx[COORD_BITS-1:0];
        vals[1] = ny[COORD_BITS-1:0];
        vals[2] = nz[COORD_BITS-1:0];
        vals[3] = ax[COORD_BITS-1:0];
        vals[4] = ay[COORD_BITS-1:0];
        vals[5] = az[COORD_BITS-1:0];
        plane_pt[0] = ax;
        plane_pt[1] = ay;
        plane_pt[2] = az;
        for (i = 0; i < 6; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= regs[i];
            cfg_ch.data <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
            sb.write_reg(regs[i], vals[i]);
            @(negedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_plane();
        longint n [3];
        longint a [3];
        logic signed [COORD_BITS-1:0] c;
        int i;
        int style;
        style = $urandom_range(0, 2);
        for (i = 0; i < 3; i++)
        begin
            case (style)
                0: n[i] = 0;
                1: n[i] = longint'($urandom_range(0, 2 * UNIT)) - UNIT;
                default: n[i] = (longint'($urandom_range(0, 2)) - 1) * UNIT;
            endcase
        end
        if (style == 0)
            n[$urandom_range(0, 2)] = $urandom_range(0, 1) ? UNIT : -UNIT;
        style = $urandom_range(0, 3);
        for (i = 0; i < 3; i++)
        begin
            case (style)
                0: a[i] = 0;
                1:
                begin
                    c = near_coord(0, 0);
                    a[i] = c;
                end
                2: a[i] = $urandom_range(0, 1) ? CMAX : CMIN;
                default:
                begin
                    c = near_coord(0, 1 << 20);
                    a[i] = c;
                end
            endcase
        end
        program_plane(n[0], n[1], n[2], a[0], a[1], a[2]);
    endtask

    // one polygon centered on the plane point; flaw 0 is well formed
    task automatic clip_polygon(int flaw);
        logic signed [COORD_BITS-1:0] xs [8];
        logic signed [COORD_BITS-1:0] ys [8];
        logic signed [COORD_BITS-1:0] zs [8];
        int n;
        int i;
        int spread;
        n = $urandom_range(1, 8);
        case ($urandom_range(0, 4))
            0: spread = 1 << 8;
            1: spread = 1 << 16;
            2: spread = 1 << 22;
            3: spread = 1 << 28;
            default: spread = 0;
        endcase
        for (i = 0; i < n; i++)
        begin
            xs[i] = near_coord(plane_pt[0], spread);
            ys[i] = near_coord(plane_pt[1], spread);
            zs[i] = near_coord(plane_pt[2], spread);
        end
        if (flaw != 1)
            send_vertex(KIND_PRIME, xs[n-1], ys[n-1], zs[n-1], $urandom_range(0, 1));
        if (flaw == 3)
            send_vertex(KIND_PRIME, xs[0], ys[0], zs[0], $urandom_range(0, 1));
        for (i = 0; i < n; i++)
            send_vertex(KIND_VERTEX, xs[i], ys[i], zs[i], (i == n - 1) && (flaw != 2));
    endtask

    always @(posedge clk)
    begin
        if ((vtx.valid && vtx.ready) || (clp.valid && clp.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL polygon_plane_clipper");
            $finish;
        end
    end

    initial
    begin : clip_sink
        int stall;
        clp.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                clp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            clp.ready <= 1'b1;
            @(posedge clk);
            while (!clp.valid)
                @(posedge clk);
            sb.check_word(clp.ox, clp.oy, clp.oz, clp.out_valid, clp.out_last);
            @(negedge clk);
        end
    end

    initial
    begin : vertex_source
        int pick;
        int units;
        sb = new();
        calm = 1'b0;
        items_sent = 0;
        plane_pt[0] = 0;
        plane_pt[1] = 0;
        plane_pt[2] = 0;
        vtx.valid = 1'b0;
        vtx.kind = KIND_PRIME;
        vtx.px = '0;
        vtx.py = '0;
        vtx.pz = '0;
        vtx.last_vertex = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_NORMAL_X;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset plane: z = 0, normal +z; first vertex starts from the origin, unprimed
        send_vertex(KIND_VERTEX, 0, 0, UNIT, 1'b0);
        send_vertex(KIND_VERTEX, CMAX, CMAX, CMIN, 1'b1);
        // last flag means nothing on a priming word
        send_vertex(KIND_PRIME, CMAX, CMIN, CMAX, 1'b1);
        send_vertex(KIND_VERTEX, CMIN, CMIN, CMIN, 1'b0);
        send_vertex(KIND_VERTEX, 0, 0, 0, 1'b0);
        send_vertex(KIND_VERTEX, CMAX, CMAX, CMAX, 1'b0);
        send_vertex(KIND_VERTEX, CMAX, CMIN, CMAX, 1'b1);
        // fully outside polygon ends in a bare marker
        send_vertex(KIND_PRIME, CMIN, CMAX, UNIT, 1'b0);
        send_vertex(KIND_VERTEX, CMAX, 0, 1, 1'b0);
        send_vertex(KIND_VERTEX, CMIN, CMAX, UNIT, 1'b1);

        settle();
        program_plane(-UNIT, 0, 0, 0, CMAX, CMIN);
        send_vertex(KIND_PRIME, CMAX, 5, 7, 1'b0);
        send_vertex(KIND_VERTEX, CMIN, CMAX, CMIN, 1'b0);
        // plane moves mid-polygon; the stored distance must stay as it was
        settle();
        program_plane(0, UNIT, UNIT, CMIN, 0, CMAX);
        send_vertex(KIND_VERTEX, 12345, -(1 << 20), 3, 1'b0);
        send_vertex(KIND_VERTEX, CMAX, CMAX, CMAX, 1'b1);

        // zero normal: everything is on the plane
        settle();
        program_plane(0, 0, 0, CMIN, CMAX, CMIN);
        send_vertex(KIND_PRIME, CMIN, CMIN, CMIN, 1'b0);
        send_vertex(KIND_VERTEX, CMAX, CMIN, CMAX, 1'b1);

        settle();
        program_plane(UNIT, UNIT, -UNIT, CMAX, CMIN, CMAX);
        send_vertex(KIND_PRIME, CMIN, CMAX, CMIN, 1'b0);
        send_vertex(KIND_VERTEX, CMAX, CMIN, CMAX, 1'b0);
        send_vertex(KIND_VERTEX, CMIN, CMAX, CMIN, 1'b1);

        while (items_sent < ITEM_TARGET)
        begin
            settle();
            random_plane();
            calm = ($urandom_range(0, 3) == 0);
            units = $urandom_range(6, 14);
            repeat (units)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    clip_polygon(0);
                else if (pick < 88)
                    clip_polygon($urandom_range(1, 3));
                else
                    send_vertex(vertex_kind_t'($urandom_range(0, 1)), near_coord(0, 0),
                                near_coord(0, 0), near_coord(0, 0), $urandom_range(0, 1));
            end
        end

        settle();
        if (sb.errors == 0)
            $display("PASS polygon_plane_clipper");
        else
            $display("FAIL polygon_plane_clipper");
        $finish;
    end
endmodule
